// ----- hw/rtl/csp_pkg.sv -----
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, codes and helper functions for the CAN signal pack/unpack
// block.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int FRAME_W  = 64;
    localparam int VALUE_W  = 32;
    localparam int EXT_W    = FRAME_W + VALUE_W;
    localparam int SHIFT_W  = 7;
    localparam int FIELD_W  = 6;
    localparam int CFG_IDX_W = 2;

    // operation codes
    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_ENCODE = 1'b1
    } t_op;

    // byte order codes
    typedef enum logic {
        ORDER_INTEL    = 1'b0,
        ORDER_MOTOROLA = 1'b1
    } t_order;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_BIT   = 2'd0,
        CFG_BIT_LENGTH  = 2'd1,
        CFG_BYTE_ORDER  = 2'd2,
        CFG_SIGN_EXTEND = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [FIELD_W-1:0] start_bit;
        logic [FIELD_W-1:0] bit_length;
        t_order             byte_order;
        logic               sign_extend;
    } t_cfg;

    typedef struct packed {
        t_op                       op;
        logic [FRAME_W-1:0]        frame_in;
        logic signed [VALUE_W-1:0] raw_value;
    } t_in;

    typedef struct packed {
        logic [FRAME_W-1:0]        frame_out;
        logic signed [VALUE_W-1:0] decoded_value;
    } t_out;

    // swap byte order of a frame word, bits within each byte keep their place
    function automatic logic [FRAME_W-1:0] byte_rev(input logic [FRAME_W-1:0] d);
        logic [FRAME_W-1:0] r;
        for (int b = 0; b < FRAME_W / 8; b++) begin
            r[b*8 +: 8] = d[(FRAME_W/8 - 1 - b)*8 +: 8];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/csp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// csp_cfg_regs
// Configuration register file: signal start bit, length, byte order and
// sign extension.
// ----------------------------------------------------------------------------
module csp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [csp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csp_pkg::FIELD_W-1:0]    i_cfg_data,
    output csp_pkg::t_cfg                  o_cfg
);

    csp_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_bit   <= '0;
            r_cfg.bit_length  <= csp_pkg::FIELD_W'(8);
            r_cfg.byte_order  <= csp_pkg::ORDER_INTEL;
            r_cfg.sign_extend <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (csp_pkg::t_cfg_idx'(i_cfg_index))
                csp_pkg::CFG_START_BIT:   r_cfg.start_bit   <= i_cfg_data;
                csp_pkg::CFG_BIT_LENGTH:  r_cfg.bit_length  <= i_cfg_data;
                csp_pkg::CFG_BYTE_ORDER:  r_cfg.byte_order  <= csp_pkg::t_order'(i_cfg_data[0]);
                csp_pkg::CFG_SIGN_EXTEND: r_cfg.sign_extend <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

// ----- hw/rtl/csp_core.sv -----
// ----------------------------------------------------------------------------
// csp_core
// Signal extract/insert datapath: aligns the signal field with one barrel
// shift and masks it in or out.
// ----------------------------------------------------------------------------
module csp_core #(
    parameter int FRAME_BYTES     = 8,
    parameter int MAX_SIGNAL_BITS = 32
) (
    input  csp_pkg::t_cfg i_cfg,
    input  csp_pkg::t_in  i_item,
    output csp_pkg::t_out o_result
);

    localparam int FW = csp_pkg::FRAME_W;
    localparam int VW = csp_pkg::VALUE_W;
    localparam int XW = csp_pkg::EXT_W;
    localparam int SW = csp_pkg::SHIFT_W;
    localparam int LW = csp_pkg::FIELD_W;

    // bits of bytes within the frame length
    localparam logic [FW-1:0] FRAME_MASK = {FW{1'b1}} >> (FW - FRAME_BYTES * 8);

    logic          len_ok;
    logic          moto;
    logic [LW-1:0] len;
    logic [LW-1:0] lin_start;
    logic [FW-1:0] frame_lim;
    logic [XW-1:0] x;
    logic [SW-1:0] sh;
    logic [VW-1:0] len_mask;
    logic [XW-1:0] x_shr;
    logic [VW-1:0] field;
    logic          neg;
    logic [VW-1:0] decoded;
    logic [XW-1:0] m_ext;
    logic [XW-1:0] d_ext;
    logic [XW-1:0] x_new;
    logic [FW-1:0] back;
    logic [FW-1:0] frame_new;

    always_comb begin
        len    = i_cfg.bit_length;
        len_ok = (len != '0) && (len <= LW'(MAX_SIGNAL_BITS));
        moto   = (i_cfg.byte_order == csp_pkg::ORDER_MOTOROLA);

        frame_lim = i_item.frame_in & FRAME_MASK;

        // motorola: bits counted msb-first within bytes, bytes ascending;
        // reversing byte order turns this into a plain msb-high field
        lin_start = {i_cfg.start_bit[LW-1:3], ~i_cfg.start_bit[2:0]};

        if (moto) begin
            x  = {csp_pkg::byte_rev(frame_lim), {VW{1'b0}}};
            sh = SW'(XW) - {1'b0, lin_start} - {1'b0, len};
        end else begin
            x  = {{VW{1'b0}}, frame_lim};
            sh = {1'b0, i_cfg.start_bit};
        end

        len_mask = {VW{1'b1}} >> (LW'(VW) - len);

        // decode
        x_shr   = x >> sh;
        field   = x_shr[VW-1:0] & len_mask;
        neg     = i_cfg.sign_extend && field[5'(len - LW'(1))];
        decoded = neg ? (field | ~len_mask) : field;

        // encode, out-of-frame bits fall off the ends
        m_ext = {{FW{1'b0}}, len_mask} << sh;
        d_ext = {{FW{1'b0}}, i_item.raw_value & len_mask} << sh;
        x_new = (x & ~m_ext) | d_ext;
        back  = moto ? csp_pkg::byte_rev(x_new[XW-1:VW]) : x_new[FW-1:0];
        frame_new = (back & FRAME_MASK) | (i_item.frame_in & ~FRAME_MASK);

        o_result.frame_out     = i_item.frame_in;
        o_result.decoded_value = '0;
        if (len_ok) begin
            if (i_item.op == csp_pkg::OP_ENCODE) begin
                o_result.frame_out = frame_new;
            end else begin
                o_result.decoded_value = decoded;
            end
        end
    end

endmodule

// ----- hw/rtl/can_signal_pack_unpack.sv -----
// ----------------------------------------------------------------------------
// can_signal_pack_unpack
// Extracts one signal from, or inserts one signal into, an 8-byte CAN frame
// with Intel or Motorola bit layout, set up through configuration registers.
// ----------------------------------------------------------------------------
// path: input transaction to the input register, then the result register
// throughput: one transaction per cycle while i_out_stall is low, set by
//   the single-pass shift/mask datapath between input and result registers
// reset: synchronous active low; pipeline emptied, registers return to
//   start_bit 0, bit_length 8, intel order, no sign extension
module can_signal_pack_unpack #(
    parameter int FRAME_BYTES     = 8,
    parameter int MAX_SIGNAL_BITS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  csp_pkg::t_in                  i_in_data,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output csp_pkg::t_out                 o_out_data,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [csp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [csp_pkg::FIELD_W-1:0]   i_cfg_data
);

    csp_pkg::t_cfg cfg;
    csp_pkg::t_out result;

    // input stage
    logic          r_v1;
    csp_pkg::t_in  r_in;
    // result stage
    logic          r_v2;
    csp_pkg::t_out r_out;

    logic          adv2;

    csp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    csp_core #(
        .FRAME_BYTES     (FRAME_BYTES),
        .MAX_SIGNAL_BITS (MAX_SIGNAL_BITS)
    ) u_core (
        .i_cfg    (cfg),
        .i_item   (r_in),
        .o_result (result)
    );

    // result register frees when empty or when its transaction is taken
    assign adv2       = !r_v2 || !i_out_stall;
    // input register holds only while the result stage cannot move
    assign o_in_stall = r_v1 && !adv2;

    assign o_out_valid = r_v2;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (!o_in_stall) begin
            r_v1 <= i_in_valid;
        end
    end

    // payload captured only on a new transaction
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_out <= result;
        end
    end

    // accepted transaction lands in the input register
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted transaction lost at input register");

    // a held input moves to the result stage once it frees up
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2) |=> r_v2)
        else $error("transaction lost between stages");

    // decode never alters the frame
    a_decode_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2 && r_in.op == csp_pkg::OP_DECODE)
            |=> (r_out.frame_out == $past(r_in.frame_in)))
        else $error("decode changed frame");

    // encode reports a zero value
    a_encode_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv2 && r_in.op == csp_pkg::OP_ENCODE)
            |=> (r_out.decoded_value == '0))
        else $error("encode gave nonzero decoded value");

endmodule
